// ===== rtl/radial_vignette_gain_top_macros.svh =====
// Assertion macros for the radial vignette gain RTL.
// Expects signals named clk and rst_n in the scope of each use.
`ifndef RADIAL_VIGNETTE_GAIN_TOP_MACROS_SVH
`define RADIAL_VIGNETTE_GAIN_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RVG_ASSERT_NOW(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, disabled during reset.
`define RVG_ASSERT_NEXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("next-cycle implication failed");

`endif

// ===== rtl/rvg_pkg.sv =====
// Package for the radial vignette gain block: fixed-point constants,
// configuration register indexes. No dependencies.
`default_nettype none

package rvg_pkg;

  localparam int Q_BITS    = 17;  // quotient bits of the Q16 dividers
  localparam int SPAN_W    = 15;  // width of the falloff span constant
  localparam int ROOT_W    = 16;  // square root result width
  localparam int HSQ_W     = 32;  // radicand width
  localparam int STRENGTH_W = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [16:0]       ONE_Q16         = 17'd65536;
  localparam logic [15:0]       FALL_START_Q16  = 16'd39322;
  localparam logic [SPAN_W-1:0] FALL_SPAN_Q16   = 15'd26214;
  localparam logic [15:0]       NEAR_ZERO_LIMIT = 16'd16;

  // Reciprocal of the falloff span: floor(n * 2^16 / FALL_SPAN_Q16) equals
  // (n * SPAN_RECIP) >> RECIP_SH for every n below 2^15.
  localparam logic [31:0]       SPAN_RECIP      = 32'd2684395521;
  localparam int                RECIP_SH        = 30;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STRENGTH = 2'd0,
    CFG_WIDTH    = 2'd1,
    CFG_HEIGHT   = 2'd2
  } cfg_idx_t;

endpackage

`default_nettype wire

// ===== rtl/rvg_if.sv =====
// Valid/ready stream interfaces for pixels into and out of the vignette block.
// No dependencies.
`default_nettype none

interface rvg_in_if #(parameter int PIX_W = 12, parameter int COLOR_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic [PIX_W-1:0]      pixel_x;
  logic [PIX_W-1:0]      pixel_y;
  logic [COLOR_BITS-1:0] red_in;
  logic [COLOR_BITS-1:0] green_in;
  logic [COLOR_BITS-1:0] blue_in;

  modport source (output valid, pixel_x, pixel_y, red_in, green_in, blue_in,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, red_in, green_in, blue_in,
                  output ready);
endinterface

interface rvg_out_if #(parameter int COLOR_BITS = 16);
  logic                  valid;
  logic                  ready;
  logic [COLOR_BITS-1:0] red_out;
  logic [COLOR_BITS-1:0] green_out;
  logic [COLOR_BITS-1:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

`default_nettype wire

// ===== rtl/radial_vignette_gain_top.sv =====
// Top level of the radial vignette gain block: configuration registers,
// front part, queue and back part. Depends on rvg_pkg, rvg_if and submodules.
`default_nettype none

// Radial vignette with a cubic falloff. Each pixel transaction carries its
// column, row and three unsigned Q4.12 colour channels; each result
// transaction carries the three scaled channels. The block accepts one pixel
// per clock while the queue is not full and returns one result per pixel in
// order. Behind the queue lie 17 stages for the two axis dividers, two for
// squaring and summing, 16 for the square root, one for the falloff
// reciprocal multiply, four for the cube and gain, and the output register.
// The rate is set by the pipelined dividers, square root and multipliers,
// which each take a new operand every cycle unless the output stalls. A
// stalled output freezes the whole back pipeline; the four-entry queue keeps
// accepting pixels until it fills.
// Configuration (strength, image width, image height) is written through a
// plain write port and must only change while the block is idle.

module radial_vignette_gain_top #(
  parameter int MAX_DIM    = 4096,
  parameter int COLOR_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [rvg_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [((($clog2(MAX_DIM+1)) > 16) ? $clog2(MAX_DIM+1) : 16)-1:0] cfg_wdata,
  rvg_in_if.sink                               in_pix,
  rvg_out_if.source                            out_pix
);

  localparam int SIZE_W = $clog2(MAX_DIM + 1);
  localparam int PIX_W  = $clog2(MAX_DIM);
  localparam int ENT_W  = 3*COLOR_BITS + 4*SIZE_W + 20;

  // Configuration registers. Unknown indexes are ignored.
  logic [rvg_pkg::STRENGTH_W-1:0] strength_r;
  logic [SIZE_W-1:0]              width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strength_r <= '0;
      width_r    <= SIZE_W'(MAX_DIM);
      height_r   <= SIZE_W'(MAX_DIM);
    end else if (cfg_we) begin
      unique case (rvg_pkg::cfg_idx_t'(cfg_idx))
        rvg_pkg::CFG_STRENGTH: strength_r <= cfg_wdata[rvg_pkg::STRENGTH_W-1:0];
        rvg_pkg::CFG_WIDTH:    width_r    <= cfg_wdata[SIZE_W-1:0];
        rvg_pkg::CFG_HEIGHT:   height_r   <= cfg_wdata[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front part classifies each pixel and pushes it into the queue.
  logic             q_push, q_full, q_pop, q_valid;
  logic [ENT_W-1:0] q_din, q_dout;

  rvg_front #(
    .MAX_DIM(MAX_DIM), .COLOR_BITS(COLOR_BITS), .SIZE_W(SIZE_W), .PIX_W(PIX_W)
  ) u_front (
    .in_pix       (in_pix),
    .strength     (strength_r),
    .image_width  (width_r),
    .image_height (height_r),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_din)
  );

  rvg_queue #(.W(ENT_W), .DEPTH(4)) u_queue (
    .clk, .rst_n,
    .push      (q_push),
    .din       (q_din),
    .full      (q_full),
    .pop       (q_pop),
    .dout      (q_dout),
    .not_empty (q_valid)
  );

  // Back part computes radius, falloff and gain, and owns the output register.
  rvg_back #(.COLOR_BITS(COLOR_BITS), .SIZE_W(SIZE_W)) u_back (
    .clk, .rst_n,
    .q_valid (q_valid),
    .q_data  (q_dout),
    .q_pop   (q_pop),
    .out_pix (out_pix)
  );

endmodule

`default_nettype wire

// ===== rtl/rvg_queue.sv =====
// Short FIFO between the front and back parts of the vignette block.
// No dependencies.
`default_nettype none

module rvg_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output logic              not_empty
);

  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  store_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   cnt_r;

  assign full      = (cnt_r == (AW+1)'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign dout      = store_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rvg_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per stage, producing a Q16
// quotient of num/den for num below twice den. Depends on rvg_pkg.
`default_nettype none

module rvg_div_pipe #(
  parameter int DEN_W = 13,
  parameter int LANES = 2,
  parameter int SB_W  = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [DEN_W:0]    num [LANES],
  input  wire logic [DEN_W-1:0]  den [LANES],
  input  wire logic [SB_W-1:0]   sb_in,
  output logic                   out_valid,
  output logic [rvg_pkg::Q_BITS-1:0] quo [LANES],
  output logic                   big [LANES],
  output logic [SB_W-1:0]        sb_out
);

  localparam int NS = rvg_pkg::Q_BITS;

  logic [DEN_W:0]   rem_r [NS][LANES];
  logic [DEN_W-1:0] den_r [NS][LANES];
  logic [NS-1:0]    quo_r [NS][LANES];
  logic             big_r [NS][LANES];
  logic [NS-1:0]    v_r;
  logic [SB_W-1:0]  sb_r [NS];

  genvar k, l;
  generate
    for (k = 0; k < NS; k++) begin : g_stage
      for (l = 0; l < LANES; l++) begin : g_lane
        logic [DEN_W:0]   r_in, r_out, d_ext;
        logic [DEN_W-1:0] d_src;
        logic [NS-1:0]    q_src;
        logic             big_src, bit_q;
        if (k == 0) begin : g_first
          assign big_src = (num[l] >= {den[l], 1'b0});
          assign r_in    = big_src ? '0 : num[l];
          assign d_src   = den[l];
          assign q_src   = '0;
        end else begin : g_next
          assign big_src = big_r[k-1][l];
          assign r_in    = {rem_r[k-1][l][DEN_W-1:0], 1'b0};
          assign d_src   = den_r[k-1][l];
          assign q_src   = quo_r[k-1][l];
        end
        assign d_ext = {1'b0, d_src};
        assign bit_q = (r_in >= d_ext);
        assign r_out = bit_q ? r_in - d_ext : r_in;
        always_ff @(posedge clk) begin
          if (en) begin
            rem_r[k][l] <= r_out;
            den_r[k][l] <= d_src;
            big_r[k][l] <= big_src;
            quo_r[k][l] <= q_src | (NS'(bit_q) << (NS-1-k));
          end
        end
      end
    end
    for (l = 0; l < LANES; l++) begin : g_out
      assign quo[l] = quo_r[NS-1][l];
      assign big[l] = big_r[NS-1][l];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= sb_in;
      for (int i = 1; i < NS; i++) begin
        sb_r[i] <= sb_r[i-1];
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign sb_out    = sb_r[NS-1];

endmodule

`default_nettype wire

// ===== rtl/rvg_sqrt_pipe.sv =====
// Pipelined integer square root of a 32-bit value, one result bit per stage.
// Depends on rvg_pkg.
`default_nettype none

module rvg_sqrt_pipe #(
  parameter int SB_W = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic [rvg_pkg::HSQ_W-1:0] radicand,
  input  wire logic [SB_W-1:0]           sb_in,
  output logic                           out_valid,
  output logic [rvg_pkg::ROOT_W-1:0]     root,
  output logic [SB_W-1:0]                sb_out
);

  localparam int NS  = rvg_pkg::ROOT_W;
  localparam int VW  = rvg_pkg::HSQ_W;
  localparam int RMW = NS + 3;

  logic [VW-1:0]  val_r  [NS];
  logic [RMW-1:0] rem_r  [NS];
  logic [NS-1:0]  root_r [NS];
  logic [NS-1:0]  v_r;
  logic [SB_W-1:0] sb_r  [NS];

  genvar k;
  generate
    for (k = 0; k < NS; k++) begin : g_stage
      logic [VW-1:0]  val_src;
      logic [RMW-1:0] rem_src, rem_sh, trial;
      logic [NS-1:0]  root_src;
      logic           ge;
      if (k == 0) begin : g_first
        assign val_src  = radicand;
        assign rem_src  = '0;
        assign root_src = '0;
      end else begin : g_next
        assign val_src  = val_r[k-1];
        assign rem_src  = rem_r[k-1];
        assign root_src = root_r[k-1];
      end
      assign rem_sh = {rem_src[RMW-3:0], val_src[VW-1-2*k -: 2]};
      assign trial  = RMW'({root_src, 2'b01});
      assign ge     = (rem_sh >= trial);
      always_ff @(posedge clk) begin
        if (en) begin
          val_r[k]  <= val_src;
          rem_r[k]  <= ge ? rem_sh - trial : rem_sh;
          root_r[k] <= {root_src[NS-2:0], ge};
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0] <= sb_in;
      for (int i = 1; i < NS; i++) begin
        sb_r[i] <= sb_r[i-1];
      end
    end
  end

  assign out_valid = v_r[NS-1];
  assign root      = root_r[NS-1];
  assign sb_out    = sb_r[NS-1];

endmodule

`default_nettype wire

// ===== rtl/rvg_front.sv =====
// Front part: accepts pixels, clamps the image size, forms axis offsets and
// classifies strength. Depends on rvg_pkg and rvg_in_if.
`default_nettype none

module rvg_front #(
  parameter int MAX_DIM    = 4096,
  parameter int COLOR_BITS = 16,
  parameter int SIZE_W     = 13,
  parameter int PIX_W      = 12
) (
  rvg_in_if.sink                                  in_pix,
  input  wire logic [rvg_pkg::STRENGTH_W-1:0]     strength,
  input  wire logic [SIZE_W-1:0]                  image_width,
  input  wire logic [SIZE_W-1:0]                  image_height,
  input  wire logic                               q_full,
  output logic                                    q_push,
  output logic [3*COLOR_BITS+4*SIZE_W+20-1:0]     q_data
);

  localparam logic [SIZE_W-1:0] MAX_SZ = SIZE_W'(MAX_DIM);

  logic [SIZE_W-1:0] w_c, h_c;
  logic [SIZE_W:0]   mag_x, mag_y;
  logic [15:0]       s_abs;
  logic              near_zero, positive;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    priority if (s == '0) r = SIZE_W'(1);
    else if (s > MAX_SZ)  r = MAX_SZ;
    else                  r = s;
    return r;
  endfunction

  function automatic logic [SIZE_W:0] axis_mag(input logic [PIX_W-1:0] p,
                                               input logic [SIZE_W-1:0] s);
    logic [SIZE_W:0] two, se, r;
    two = (SIZE_W+1)'({p, 1'b0});
    se  = {1'b0, s};
    r   = (two >= se) ? two - se : se - two;
    return r;
  endfunction

  assign w_c   = clamp_size(image_width);
  assign h_c   = clamp_size(image_height);
  assign mag_x = axis_mag(in_pix.pixel_x, w_c);
  assign mag_y = axis_mag(in_pix.pixel_y, h_c);

  assign s_abs     = strength[15] ? 16'(-strength) : strength;
  assign near_zero = (s_abs <= rvg_pkg::NEAR_ZERO_LIMIT);
  assign positive  = !strength[15] && (strength != '0);

  assign in_pix.ready = !q_full;
  assign q_push       = in_pix.valid && !q_full;
  assign q_data = {in_pix.blue_in, in_pix.green_in, in_pix.red_in,
                   near_zero, positive, s_abs, h_c, mag_y, w_c, mag_x};

endmodule

`default_nettype wire

// ===== rtl/rvg_back.sv =====
// Back part: radius, falloff and per-channel gain pipeline with output
// register. Depends on rvg_pkg, rvg_out_if, rvg_div_pipe, rvg_sqrt_pipe.
`default_nettype none
`include "radial_vignette_gain_top_macros.svh"

module rvg_back #(
  parameter int COLOR_BITS = 16,
  parameter int SIZE_W     = 13
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               q_valid,
  input  wire logic [3*COLOR_BITS+4*SIZE_W+20-1:0] q_data,
  output logic                                    q_pop,
  rvg_out_if.source                               out_pix
);

  localparam int CB  = COLOR_BITS;
  localparam int SB1 = 3*CB + 18;
  localparam int QB  = rvg_pkg::Q_BITS;
  localparam logic [CB-1:0] CMAX = {CB{1'b1}};

  logic en;

  // Queue entry fields.
  logic [CB-1:0]     e_r, e_g, e_b;
  logic              e_nz, e_pos;
  logic [15:0]       e_sabs;
  logic [SIZE_W-1:0] e_w, e_h;
  logic [SIZE_W:0]   e_mx, e_my;

  assign {e_b, e_g, e_r, e_nz, e_pos, e_sabs, e_h, e_my, e_w, e_mx} = q_data;

  assign en    = !out_pix.valid || out_pix.ready;
  assign q_pop = en && q_valid;

  // Axis offsets.
  logic [SIZE_W:0]   ax_num [2];
  logic [SIZE_W-1:0] ax_den [2];
  logic [QB-1:0]     ax_q   [2];
  logic              ax_big [2];
  logic              vd;
  logic [SB1-1:0]    sbd;

  assign ax_num[0] = e_mx;
  assign ax_num[1] = e_my;
  assign ax_den[0] = e_w;
  assign ax_den[1] = e_h;

  rvg_div_pipe #(.DEN_W(SIZE_W), .LANES(2), .SB_W(SB1)) u_div_xy (
    .clk, .rst_n, .en,
    .in_valid (q_pop),
    .num      (ax_num),
    .den      (ax_den),
    .sb_in    ({e_b, e_g, e_r, e_nz, e_pos, e_sabs}),
    .out_valid(vd),
    .quo      (ax_q),
    .big      (ax_big),
    .sb_out   (sbd)
  );

  logic [17:0] dx, dy;
  assign dx = ax_big[0] ? 18'd131072 : {1'b0, ax_q[0]};
  assign dy = ax_big[1] ? 18'd131072 : {1'b0, ax_q[1]};

  // Squares, then half sum.
  logic           v1_r, v2_r;
  logic [35:0]    sqx_r, sqy_r;
  logic [SB1-1:0] sb1_r, sb2_r;
  logic [36:0]    sum1;
  logic [31:0]    hs2_r;
  logic           sat2_r;

  assign sum1 = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_ff @(posedge clk) begin
    if (en) begin
      sqx_r  <= dx * dx;
      sqy_r  <= dy * dy;
      sb1_r  <= sbd;
      hs2_r  <= sum1[32:1];
      sat2_r <= |sum1[36:33];
      sb2_r  <= sb1_r;
    end
  end

  // Radius.
  logic                       vs;
  logic [rvg_pkg::ROOT_W-1:0] root;
  logic [SB1:0]               sbs;
  logic [16:0]                d3, dm3;
  logic                       inner3;
  logic [15:0]                num_t;
  logic [47:0]                p_t;

  rvg_sqrt_pipe #(.SB_W(SB1+1)) u_sqrt (
    .clk, .rst_n, .en,
    .in_valid (v2_r),
    .radicand (hs2_r),
    .sb_in    ({sb2_r, sat2_r}),
    .out_valid(vs),
    .root     (root),
    .sb_out   (sbs)
  );

  assign d3     = sbs[0] ? rvg_pkg::ONE_Q16 : {1'b0, root};
  assign inner3 = (d3 < {1'b0, rvg_pkg::FALL_START_Q16});
  assign dm3    = d3 - {1'b0, rvg_pkg::FALL_START_Q16};
  assign num_t  = inner3 ? '0 : dm3[15:0];

  // Falloff position t. The division by the constant span is a reciprocal
  // multiplication, exact for every offset up to the span.
  assign p_t = num_t * rvg_pkg::SPAN_RECIP;

  logic           vt_r;
  logic [16:0]    tq_r;
  logic [SB1:0]   sbt_r;
  logic [16:0]    t4;

  always_ff @(posedge clk) begin
    if (en) begin
      tq_r  <= p_t[rvg_pkg::RECIP_SH +: 17];
      sbt_r <= {sbs[SB1:1], inner3};
    end
  end

  assign t4 = (tq_r > rvg_pkg::ONE_Q16) ? rvg_pkg::ONE_Q16 : tq_r;

  // Cube, strength, gain.
  logic           v4_r, v5_r, v6_r, v7_r;
  logic [16:0]    t2_r, tk_r, t3_r;
  logic [18:0]    mag6_r;
  logic [SB1:0]   sb4_r, sb5_r, sb6_r;
  logic [SB1-1:0] sb7_r;
  logic           gz7_r;
  logic [17:0]    gmag7_r;
  logic [33:0]    p_t2, p_t3;
  logic [32:0]    p_mag;
  logic           pos6, nz6, inner6;

  assign p_t2   = t4 * t4;
  assign p_t3   = t2_r * tk_r;
  assign p_mag  = t3_r * sb5_r[16:1];
  assign inner6 = sb6_r[0];
  assign pos6   = sb6_r[17];
  assign nz6    = sb6_r[18];

  always_ff @(posedge clk) begin
    if (en) begin
      t2_r   <= p_t2[32:16];
      tk_r   <= t4;
      sb4_r  <= sbt_r;
      t3_r   <= p_t3[32:16];
      sb5_r  <= sb4_r;
      mag6_r <= p_mag[32:14];
      sb6_r  <= sb5_r;
      sb7_r  <= sb6_r[SB1:1];
      priority if (nz6 || inner6) begin
        gz7_r   <= 1'b0;
        gmag7_r <= 18'(rvg_pkg::ONE_Q16);
      end else if (pos6) begin
        gz7_r   <= (mag6_r >= 19'(rvg_pkg::ONE_Q16));
        gmag7_r <= 18'(rvg_pkg::ONE_Q16) - mag6_r[17:0];
      end else begin
        gz7_r   <= 1'b0;
        gmag7_r <= 18'(rvg_pkg::ONE_Q16) + mag6_r[17:0];
      end
    end
  end

  // Channel scaling into the output register.
  logic [CB-1:0]  red_r, green_r, blue_r;
  logic           out_valid_r;
  logic [CB-1:0]  c7 [3];
  logic [CB-1:0]  s7 [3];

  assign c7[0] = sb7_r[18 +: CB];
  assign c7[1] = sb7_r[18+CB +: CB];
  assign c7[2] = sb7_r[18+2*CB +: CB];

  genvar ci;
  generate
    for (ci = 0; ci < 3; ci++) begin : g_ch
      logic [CB+17:0] prod;
      logic [CB+1:0]  sh;
      assign prod = c7[ci] * gmag7_r;
      assign sh   = prod[CB+17:16];
      assign s7[ci] = gz7_r ? '0 : (sh > {2'b00, CMAX}) ? CMAX : sh[CB-1:0];
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      red_r   <= s7[0];
      green_r <= s7[1];
      blue_r  <= s7[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      vt_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= vd;
      v2_r        <= v1_r;
      vt_r        <= vs;
      v4_r        <= vt_r;
      v5_r        <= v4_r;
      v6_r        <= v5_r;
      v7_r        <= v6_r;
      out_valid_r <= v7_r;
    end
  end

  assign out_pix.valid     = out_valid_r;
  assign out_pix.red_out   = red_r;
  assign out_pix.green_out = green_r;
  assign out_pix.blue_out  = blue_r;

  `RVG_ASSERT_NOW(a_t_square_range, v4_r, (t2_r <= rvg_pkg::ONE_Q16))
  `RVG_ASSERT_NEXT(a_zero_gain_black, (v7_r && en && gz7_r), (out_valid_r && red_r == '0 && blue_r == '0))
  `RVG_ASSERT_NEXT(a_unity_gain_pass, (v7_r && en && !gz7_r && gmag7_r == 18'(rvg_pkg::ONE_Q16)), (red_r == $past(c7[0]) && green_r == $past(c7[1])))

endmodule

`default_nettype wire
